/* design/psmc_pkg.sv */
package psmc_pkg;

   // Default capacity of one point set
   localparam int unsigned MAX_POINTS_DEF = 65536;

   // Field and accumulator widths
   localparam int unsigned COORD_W     = 16;
   localparam int unsigned SUM_W       = 33;
   localparam int unsigned PROD_W      = 49;
   localparam int unsigned MEAN_W      = 16;
   localparam int unsigned COV_W       = 32;
   localparam int unsigned COUNT_OUT_W = 17;

   // 1.0 in the Q15.16 covariance format
   localparam logic signed [COV_W-1:0] COV_ONE = COV_W'(1 << 16);

   // Three means, then six covariance entries, go through the divider
   localparam int unsigned NUM_AXES  = 3;
   localparam int unsigned NUM_COV   = 6;
   localparam int unsigned NUM_DIV   = NUM_AXES + NUM_COV;
   localparam int unsigned DIV_IDX_W = $clog2(NUM_DIV);
   localparam int unsigned STEP_W    = $clog2(PROD_W);

   // Request function codes
   localparam logic FUNC_ADD    = 1'b0;
   localparam logic FUNC_FINISH = 1'b1;

   typedef logic [DIV_IDX_W-1:0] div_idx_type;

   // Controller to datapath commands
   typedef struct packed {
      logic        add;       // accumulate the point on the request port
      logic        drop;      // point refused, set is full
      logic        load;      // load the divider with operand idx
      logic        div_step;  // one quotient bit
      logic        sign_fix;  // restore the quotient sign
      logic        store;     // write mean or covariance entry idx
      logic        clear;     // snapshot count and flag, clear the set
      div_idx_type idx;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic full;
   } dp_status_type;

endpackage

/* design/point_set_mean_covariance.sv */
// Mean and covariance of a streamed set of 3D points.
// Request channel (req_): func ADD accumulates coord_x/y/z (signed Q7.8)
// into a point count, three coordinate sums and six product sums; func
// FINISH closes the set and produces one response word. ADD words cause no
// response. Adds are taken one per cycle, back to back, except while a finish divides.
// Response channel (rsp_): three Q7.8 means, six Q15.16 covariance entries,
// the point count and an overflow flag. An empty set gives zero means and
// unit variances. Points past MAX_POINTS are dropped and flag overflowed.
// Finish: the set runs nine divisions through one shared restoring divider,
// one quotient bit per cycle, each with load, sign and store, so the
// response is valid once the last store has been done.
// While a response waits under rsp_stall the set is already cleared and ADD
// words are still taken; a new FINISH waits until the response is taken.
// Reset (synchronous, active high) empties the set and drops any response.
module point_set_mean_covariance #(
   parameter int unsigned MAX_POINTS = psmc_pkg::MAX_POINTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic signed [psmc_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [psmc_pkg::COORD_W-1:0] req_coord_y,
   input  logic signed [psmc_pkg::COORD_W-1:0] req_coord_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [psmc_pkg::MEAN_W-1:0]  rsp_mean_x,
   output logic signed [psmc_pkg::MEAN_W-1:0]  rsp_mean_y,
   output logic signed [psmc_pkg::MEAN_W-1:0]  rsp_mean_z,
   output logic signed [psmc_pkg::COV_W-1:0]   rsp_cov_xx,
   output logic signed [psmc_pkg::COV_W-1:0]   rsp_cov_xy,
   output logic signed [psmc_pkg::COV_W-1:0]   rsp_cov_xz,
   output logic signed [psmc_pkg::COV_W-1:0]   rsp_cov_yy,
   output logic signed [psmc_pkg::COV_W-1:0]   rsp_cov_yz,
   output logic signed [psmc_pkg::COV_W-1:0]   rsp_cov_zz,
   output logic [psmc_pkg::COUNT_OUT_W-1:0]    rsp_point_count,
   output logic                                rsp_overflowed
);
   import psmc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   psmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   psmc_dpath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .coord_x     (req_coord_x),
      .coord_y     (req_coord_y),
      .coord_z     (req_coord_z),
      .mean_x      (rsp_mean_x),
      .mean_y      (rsp_mean_y),
      .mean_z      (rsp_mean_z),
      .cov_xx      (rsp_cov_xx),
      .cov_xy      (rsp_cov_xy),
      .cov_xz      (rsp_cov_xz),
      .cov_yy      (rsp_cov_yy),
      .cov_yz      (rsp_cov_yz),
      .cov_zz      (rsp_cov_zz),
      .point_count (rsp_point_count),
      .overflowed  (rsp_overflowed)
   );

endmodule

/* design/psmc_ctrl.sv */
module psmc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_func,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  psmc_pkg::dp_status_type status,
   output psmc_pkg::dp_cmd_type    cmd
);
   import psmc_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_LOAD  = 6'b000010,
      ST_DIV   = 6'b000100,
      ST_SIGN  = 6'b001000,
      ST_STORE = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PROD_W - 1);
   localparam div_idx_type       LAST_IDX  = DIV_IDX_W'(NUM_DIV - 1);

   state_type         state_ff, state_in;
   div_idx_type       idx_ff, idx_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              req_accept;

   // Points are taken when idle and while a result waits; a finish only when idle
   assign req_stall  = !((state_ff == ST_IDLE) ||
                         ((state_ff == ST_EMIT) && (req_func == FUNC_ADD)));
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (state_ff == ST_EMIT);

   // Sequencer: nine divisions, each load, PROD_W steps, sign, store
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.idx  = idx_ff;
      cmd.add  = req_accept && (req_func == FUNC_ADD) && !status.full;
      cmd.drop = req_accept && (req_func == FUNC_ADD) && status.full;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_func == FUNC_FINISH)) begin
               idx_in   = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            cmd.sign_fix = 1'b1;
            state_in     = ST_STORE;
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            if (idx_ff == LAST_IDX) begin
               cmd.clear = 1'b1;
               state_in  = ST_EMIT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         step_ff  <= step_in;
      end
   end

endmodule

/* design/psmc_dpath.sv */
module psmc_dpath #(
   parameter int unsigned MAX_POINTS = psmc_pkg::MAX_POINTS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  psmc_pkg::dp_cmd_type                        cmd,
   output psmc_pkg::dp_status_type                     status,
   input  logic signed [psmc_pkg::COORD_W-1:0]         coord_x,
   input  logic signed [psmc_pkg::COORD_W-1:0]         coord_y,
   input  logic signed [psmc_pkg::COORD_W-1:0]         coord_z,
   output logic signed [psmc_pkg::MEAN_W-1:0]          mean_x,
   output logic signed [psmc_pkg::MEAN_W-1:0]          mean_y,
   output logic signed [psmc_pkg::MEAN_W-1:0]          mean_z,
   output logic signed [psmc_pkg::COV_W-1:0]           cov_xx,
   output logic signed [psmc_pkg::COV_W-1:0]           cov_xy,
   output logic signed [psmc_pkg::COV_W-1:0]           cov_xz,
   output logic signed [psmc_pkg::COV_W-1:0]           cov_yy,
   output logic signed [psmc_pkg::COV_W-1:0]           cov_yz,
   output logic signed [psmc_pkg::COV_W-1:0]           cov_zz,
   output logic [psmc_pkg::COUNT_OUT_W-1:0]            point_count,
   output logic                                        overflowed
);
   import psmc_pkg::*;

   localparam int unsigned CNT_W     = $clog2(MAX_POINTS + 1);
   localparam int unsigned CNT_EXT_W = CNT_W + COUNT_OUT_W;
   localparam int unsigned AX_IDX_W  = $clog2(NUM_AXES);
   localparam int unsigned COV_IDX_W = $clog2(NUM_COV);
   localparam int unsigned PRD_W     = 2 * COORD_W;
   localparam int unsigned MP_W      = 2 * MEAN_W;
   localparam int unsigned DIFF_W    = PROD_W + 1;

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

   localparam logic [AX_IDX_W-1:0] AXIS_X = AX_IDX_W'(0);
   localparam logic [AX_IDX_W-1:0] AXIS_Y = AX_IDX_W'(1);
   localparam logic [AX_IDX_W-1:0] AXIS_Z = AX_IDX_W'(2);

   localparam logic signed [PROD_W-1:0] MEAN_HI = PROD_W'(2 ** (MEAN_W - 1) - 1);
   localparam logic signed [PROD_W-1:0] MEAN_LO = -MEAN_HI - 1;
   localparam logic signed [DIFF_W-1:0] COV_HI  = DIFF_W'(2 ** (COV_W - 1) - 1);
   localparam logic signed [DIFF_W-1:0] COV_LO  = -COV_HI - 1;

   // Covariance entry k is the product of axes cov_a(k) and cov_b(k):
   // xx, xy, xz, yy, yz, zz
   function automatic logic [AX_IDX_W-1:0] cov_a(input logic [COV_IDX_W-1:0] k);
      logic [AX_IDX_W-1:0] a;
      case (k)
         3'd0, 3'd1, 3'd2: a = AXIS_X;
         3'd3, 3'd4:       a = AXIS_Y;
         default:          a = AXIS_Z;
      endcase
      return a;
   endfunction

   function automatic logic [AX_IDX_W-1:0] cov_b(input logic [COV_IDX_W-1:0] k);
      logic [AX_IDX_W-1:0] b;
      case (k)
         3'd0:       b = AXIS_X;
         3'd1, 3'd3: b = AXIS_Y;
         default:    b = AXIS_Z;
      endcase
      return b;
   endfunction

   function automatic logic signed [MEAN_W-1:0] sat_mean(input logic signed [PROD_W-1:0] v);
      logic signed [MEAN_W-1:0] r;
      if (v > MEAN_HI) begin
         r = MEAN_HI[MEAN_W-1:0];
      end else if (v < MEAN_LO) begin
         r = MEAN_LO[MEAN_W-1:0];
      end else begin
         r = v[MEAN_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [COV_W-1:0] sat_cov(input logic signed [DIFF_W-1:0] v);
      logic signed [COV_W-1:0] r;
      if (v > COV_HI) begin
         r = COV_HI[COV_W-1:0];
      end else if (v < COV_LO) begin
         r = COV_LO[COV_W-1:0];
      end else begin
         r = v[COV_W-1:0];
      end
      return r;
   endfunction

   // Set accumulators
   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [SUM_W-1:0]   sum_ff [NUM_AXES];
   logic signed [SUM_W-1:0]   sum_in [NUM_AXES];
   logic signed [PROD_W-1:0]  psum_ff [NUM_COV];
   logic signed [PROD_W-1:0]  psum_in [NUM_COV];
   logic                      drop_ff, drop_in;
   logic signed [PRD_W-1:0]   prod_ff [NUM_COV];
   logic signed [PRD_W-1:0]   prod_in [NUM_COV];
   logic                      pv_ff, pv_in;
   logic signed [COORD_W-1:0] coord [NUM_AXES];

   // Divider and finishing
   logic [CNT_W-1:0]          rem_ff, rem_in;
   logic [PROD_W-1:0]         quo_ff, quo_in;
   logic                      neg_ff, neg_in;
   logic signed [PROD_W-1:0]  q_ff, q_in;
   logic signed [MP_W-1:0]    mprod_ff, mprod_in;
   logic signed [PROD_W-1:0]  dividend;
   logic [CNT_W:0]            trial;
   logic                      trial_ge;
   div_idx_type               cov_sel;
   logic [COV_IDX_W-1:0]      cov_k;
   logic signed [MEAN_W-1:0]  mean_a, mean_b;
   logic signed [DIFF_W-1:0]  diff;
   logic [CNT_EXT_W-1:0]      count_ext;

   // Result registers
   logic signed [MEAN_W-1:0]  mean_x_ff, mean_y_ff, mean_z_ff;
   logic signed [COV_W-1:0]   cov_ff [NUM_COV];
   logic [COUNT_OUT_W-1:0]    out_count_ff;
   logic                      out_drop_ff;

   assign coord[0] = coord_x;
   assign coord[1] = coord_y;
   assign coord[2] = coord_z;

   assign status.full = (count_ff >= CNT_MAX);

   // Accumulate: coordinate sums at once, products in the cycle after
   always_comb begin
      count_in = count_ff;
      drop_in  = drop_ff;
      pv_in    = cmd.add;
      for (int i = 0; i < NUM_AXES; i++) begin
         sum_in[i] = sum_ff[i];
      end
      for (int k = 0; k < NUM_COV; k++) begin
         prod_in[k] = coord[cov_a(COV_IDX_W'(k))] * coord[cov_b(COV_IDX_W'(k))];
         psum_in[k] = psum_ff[k];
         if (pv_ff) begin
            psum_in[k] = psum_ff[k] + PROD_W'(prod_ff[k]);
         end
      end
      if (cmd.add) begin
         count_in = count_ff + 1'b1;
         for (int i = 0; i < NUM_AXES; i++) begin
            sum_in[i] = sum_ff[i] + SUM_W'(coord[i]);
         end
      end
      if (cmd.drop) begin
         drop_in = 1'b1;
      end
      if (cmd.clear) begin
         count_in = '0;
         drop_in  = 1'b0;
         for (int i = 0; i < NUM_AXES; i++) begin
            sum_in[i] = '0;
         end
         for (int k = 0; k < NUM_COV; k++) begin
            psum_in[k] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         drop_ff  <= 1'b0;
         pv_ff    <= 1'b0;
         for (int i = 0; i < NUM_AXES; i++) begin
            sum_ff[i] <= '0;
         end
         for (int k = 0; k < NUM_COV; k++) begin
            psum_ff[k] <= '0;
         end
      end else begin
         count_ff <= count_in;
         drop_ff  <= drop_in;
         pv_ff    <= pv_in;
         for (int i = 0; i < NUM_AXES; i++) begin
            sum_ff[i] <= sum_in[i];
         end
         for (int k = 0; k < NUM_COV; k++) begin
            psum_ff[k] <= psum_in[k];
         end
      end
   end

   // Operand select: coordinate sums first, then product sums
   assign cov_sel = cmd.idx - DIV_IDX_W'(NUM_AXES);
   assign cov_k   = cov_sel[COV_IDX_W-1:0];

   always_comb begin
      if (cmd.idx < DIV_IDX_W'(NUM_AXES)) begin
         dividend = PROD_W'(sum_ff[cmd.idx[AX_IDX_W-1:0]]);
      end else begin
         dividend = psum_ff[cov_k];
      end
   end

   // Means feeding the product term of the current covariance entry
   always_comb begin
      case (cov_a(cov_k))
         AXIS_X:  mean_a = mean_x_ff;
         AXIS_Y:  mean_a = mean_y_ff;
         default: mean_a = mean_z_ff;
      endcase
      case (cov_b(cov_k))
         AXIS_X:  mean_b = mean_x_ff;
         AXIS_Y:  mean_b = mean_y_ff;
         default: mean_b = mean_z_ff;
      endcase
   end

   assign mprod_in = mean_a * mean_b;

   // Restoring divider on the magnitude, one quotient bit per cycle
   assign trial    = {rem_ff, quo_ff[PROD_W-1]};
   assign trial_ge = (trial >= {1'b0, count_ff});

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      neg_in = neg_ff;
      q_in   = q_ff;
      if (cmd.load) begin
         rem_in = '0;
         neg_in = dividend[PROD_W-1];
         quo_in = dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);
      end
      if (cmd.div_step) begin
         rem_in = trial_ge ? CNT_W'(trial - {1'b0, count_ff}) : trial[CNT_W-1:0];
         quo_in = {quo_ff[PROD_W-2:0], trial_ge};
      end
      if (cmd.sign_fix) begin
         q_in = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
      end
   end

   assign diff      = DIFF_W'(q_ff) - DIFF_W'(mprod_ff);
   assign count_ext = CNT_EXT_W'(count_ff);

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      neg_ff   <= neg_in;
      q_ff     <= q_in;
      mprod_ff <= mprod_in;
      prod_ff  <= prod_in;
      // Write back one result entry; an empty set gives zero mean, unit covariance
      if (cmd.store) begin
         if (cmd.idx < DIV_IDX_W'(NUM_AXES)) begin
            case (cmd.idx[AX_IDX_W-1:0])
               AXIS_X:  mean_x_ff <= (count_ff == '0) ? '0 : sat_mean(q_ff);
               AXIS_Y:  mean_y_ff <= (count_ff == '0) ? '0 : sat_mean(q_ff);
               default: mean_z_ff <= (count_ff == '0) ? '0 : sat_mean(q_ff);
            endcase
         end else if (count_ff == '0) begin
            cov_ff[cov_k] <= (cov_a(cov_k) == cov_b(cov_k)) ? COV_ONE : '0;
         end else begin
            cov_ff[cov_k] <= sat_cov(diff);
         end
      end
      if (cmd.clear) begin
         out_count_ff <= count_ext[COUNT_OUT_W-1:0];
         out_drop_ff  <= drop_ff;
      end
   end

   assign mean_x      = mean_x_ff;
   assign mean_y      = mean_y_ff;
   assign mean_z      = mean_z_ff;
   assign cov_xx      = cov_ff[0];
   assign cov_xy      = cov_ff[1];
   assign cov_xz      = cov_ff[2];
   assign cov_yy      = cov_ff[3];
   assign cov_yz      = cov_ff[4];
   assign cov_zz      = cov_ff[5];
   assign point_count = out_count_ff;
   assign overflowed  = out_drop_ff;

endmodule

/* test/point_set_mean_covariance_tb.sv */
`timescale 1ns / 1ps

module point_set_mean_covariance_tb;
   import psmc_pkg::*;

   localparam int unsigned CAPACITY = MAX_POINTS_DEF;

   // one response word: means, covariance entries, count and flag
   typedef struct {
      logic signed [MEAN_W-1:0] mean [NUM_AXES];
      logic signed [COV_W-1:0]  cov [NUM_COV];
      logic [COUNT_OUT_W-1:0]   count;
      logic                     overflowed;
   } set_stats_type;

   // running moments of the open set and the stats still owed by the block
   class set_board_type;
      int unsigned              n_points;
      logic signed [SUM_W-1:0]  coord_sum [NUM_AXES];
      logic signed [PROD_W-1:0] prod_sum [NUM_COV];
      bit                       dropped;
      set_stats_type            expected_stats [$];
      int                       mismatches;
      int                       axis_a [NUM_COV] = '{0, 0, 0, 1, 1, 2};
      int                       axis_b [NUM_COV] = '{0, 1, 2, 1, 2, 2};
      string                    mean_name [NUM_AXES] = '{"mean_x", "mean_y", "mean_z"};
      string                    cov_name [NUM_COV] =
         '{"cov_xx", "cov_xy", "cov_xz", "cov_yy", "cov_yz", "cov_zz"};

      function new();
         mismatches = 0;
         clear_set();
      endfunction

      function void clear_set();
         n_points = 0;
         dropped  = 1'b0;
         foreach (coord_sum[i]) coord_sum[i] = '0;
         foreach (prod_sum[k]) prod_sum[k] = '0;
      endfunction

      task report(string text);
         $display("[%0t] mismatch: %s", $realtime, text);
         mismatches++;
      endtask

      function longint clip(longint v, int w);
         longint hi;
         longint lo;
         hi = (longint'(1) << (w - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      function int pending();
         return expected_stats.size();
      endfunction

      // accepted request word: accumulate, or close the set
      function void note_word(logic func, logic signed [COORD_W-1:0] x,
                              logic signed [COORD_W-1:0] y,
                              logic signed [COORD_W-1:0] z);
         longint        c [NUM_AXES];
         longint        m [NUM_AXES];
         longint        n;
         set_stats_type st;
         if (func == FUNC_ADD) begin
            // full set drops the point and remembers it
            if (n_points >= CAPACITY) begin
               dropped = 1'b1;
               return;
            end
            c[0] = x;
            c[1] = y;
            c[2] = z;
            for (int i = 0; i < NUM_AXES; i++)
               coord_sum[i] = SUM_W'(coord_sum[i] + c[i]);
            for (int k = 0; k < NUM_COV; k++)
               prod_sum[k] = PROD_W'(prod_sum[k] + c[axis_a[k]] * c[axis_b[k]]);
            n_points++;
         end else begin
            n = n_points;
            if (n == 0) begin
               // empty set: zero mean, unit variances
               for (int i = 0; i < NUM_AXES; i++) st.mean[i] = '0;
               for (int k = 0; k < NUM_COV; k++)
                  st.cov[k] = (axis_a[k] == axis_b[k]) ? COV_ONE : '0;
            end else begin
               // truncating divides, then mean products off the averaged sums
               for (int i = 0; i < NUM_AXES; i++) begin
                  m[i] = clip(longint'(coord_sum[i]) / n, MEAN_W);
                  st.mean[i] = MEAN_W'(m[i]);
               end
               for (int k = 0; k < NUM_COV; k++)
                  st.cov[k] = COV_W'(clip(longint'(prod_sum[k]) / n
                                          - m[axis_a[k]] * m[axis_b[k]], COV_W));
            end
            st.count      = COUNT_OUT_W'(n_points);
            st.overflowed = dropped;
            expected_stats.push_back(st);
            clear_set();
         end
      endfunction

      // accepted response word against the oldest owed stats
      task check_word(set_stats_type got);
         set_stats_type want;
         if (expected_stats.size() == 0) begin
            report("response word with no finish pending");
            return;
         end
         want = expected_stats.pop_front();
         for (int i = 0; i < NUM_AXES; i++)
            if (got.mean[i] !== want.mean[i])
               report($sformatf("%s got %0d want %0d", mean_name[i], got.mean[i],
                                want.mean[i]));
         for (int k = 0; k < NUM_COV; k++)
            if (got.cov[k] !== want.cov[k])
               report($sformatf("%s got %0d want %0d", cov_name[k], got.cov[k],
                                want.cov[k]));
         if (got.count !== want.count)
            report($sformatf("point_count got %0d want %0d", got.count, want.count));
         if (got.overflowed !== want.overflowed)
            report($sformatf("overflowed got %0b want %0b", got.overflowed,
                             want.overflowed));
      endtask
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_func;
   logic signed [COORD_W-1:0] req_coord_x;
   logic signed [COORD_W-1:0] req_coord_y;
   logic signed [COORD_W-1:0] req_coord_z;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic signed [MEAN_W-1:0]  rsp_mean_x;
   logic signed [MEAN_W-1:0]  rsp_mean_y;
   logic signed [MEAN_W-1:0]  rsp_mean_z;
   logic signed [COV_W-1:0]   rsp_cov_xx;
   logic signed [COV_W-1:0]   rsp_cov_xy;
   logic signed [COV_W-1:0]   rsp_cov_xz;
   logic signed [COV_W-1:0]   rsp_cov_yy;
   logic signed [COV_W-1:0]   rsp_cov_yz;
   logic signed [COV_W-1:0]   rsp_cov_zz;
   logic [COUNT_OUT_W-1:0]    rsp_point_count;
   logic                      rsp_overflowed;

   set_board_type board;
   int            gap_pct;
   int            stall_pct;
   int            words_sent;

   point_set_mean_covariance #(
      .MAX_POINTS(CAPACITY)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_coord_x(req_coord_x),
      .req_coord_y(req_coord_y),
      .req_coord_z(req_coord_z),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_mean_x(rsp_mean_x),
      .rsp_mean_y(rsp_mean_y),
      .rsp_mean_z(rsp_mean_z),
      .rsp_cov_xx(rsp_cov_xx),
      .rsp_cov_xy(rsp_cov_xy),
      .rsp_cov_xz(rsp_cov_xz),
      .rsp_cov_yy(rsp_cov_yy),
      .rsp_cov_yz(rsp_cov_yz),
      .rsp_cov_zz(rsp_cov_zz),
      .rsp_point_count(rsp_point_count),
      .rsp_overflowed(rsp_overflowed)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // receiver back-pressure, changed on the falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // response monitor
   always @(posedge clock) begin : watch_rsp
      set_stats_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.mean[0]    = rsp_mean_x;
         got.mean[1]    = rsp_mean_y;
         got.mean[2]    = rsp_mean_z;
         got.cov[0]     = rsp_cov_xx;
         got.cov[1]     = rsp_cov_xy;
         got.cov[2]     = rsp_cov_xz;
         got.cov[3]     = rsp_cov_yy;
         got.cov[4]     = rsp_cov_yz;
         got.cov[5]     = rsp_cov_zz;
         got.count      = rsp_point_count;
         got.overflowed = rsp_overflowed;
         board.check_word(got);
      end
   end

   // extremes, small values and full range
   function automatic logic signed [COORD_W-1:0] rand_coord();
      int pick;
      pick = $urandom_range(9);
      case (pick)
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2, 3, 4: return $signed(COORD_W'($urandom_range(128))) - 16'sd64;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   // entered and left on a falling edge; a word is noted on the falling edge after it is taken
   task automatic send_word(input logic func, input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y,
                            input logic signed [COORD_W-1:0] z);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= func;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      board.note_word(func, x, y, z);
      words_sent++;
   endtask

   task automatic send_set(input int size);
      for (int i = 0; i < size; i++)
         send_word(FUNC_ADD, rand_coord(), rand_coord(), rand_coord());
      send_word(FUNC_FINISH, rand_coord(), rand_coord(), rand_coord());
   endtask

   // sender holds off until every owed response is in
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (board.pending() != 0) @(negedge clock);
   endtask

   // random sets, mostly small, with quiet bursts and the odd full drain
   task automatic run_phase(input int sender_pct, input int receiver_pct, input int words);
      int stop;
      int pick;
      int size;
      bit burst;
      stop = words_sent + words;
      while (words_sent < stop) begin
         burst     = ($urandom_range(5) == 0);
         gap_pct   = burst ? 0 : sender_pct;
         stall_pct = burst ? 0 : receiver_pct;
         pick = $urandom_range(99);
         if (pick < 10)
            size = 0;
         else if (pick < 85)
            size = $urandom_range(8, 1);
         else
            size = $urandom_range(40, 9);
         send_set(size);
         if ($urandom_range(24) == 0) wait_for_results();
      end
      wait_for_results();
   endtask

   initial begin
      #100_000_000;
      $display("[point_set_mean_covariance] ERROR");
      $finish;
   end

   initial begin
      board       = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_func    = FUNC_ADD;
      req_coord_x = '0;
      req_coord_y = '0;
      req_coord_z = '0;
      rsp_stall   = 1'b0;
      gap_pct     = 26;
      stall_pct   = 63;
      words_sent  = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // empty sets, with junk on the ignored coordinates
      send_word(FUNC_FINISH, 16'sd0, 16'sd0, 16'sd0);
      send_word(FUNC_FINISH, 16'sh8000, 16'sh7FFF, -16'sd1);
      // single point at the extremes: mean is the point, covariance zero
      send_word(FUNC_ADD, 16'sh8000, 16'sh7FFF, 16'sh8000);
      send_word(FUNC_FINISH, 16'sd0, 16'sd0, 16'sd0);
      // opposite extremes: means truncate toward zero
      send_word(FUNC_ADD, 16'sh7FFF, 16'sh8000, -16'sd1);
      send_word(FUNC_ADD, 16'sh8000, 16'sh7FFF, 16'sd2);
      send_word(FUNC_FINISH, 16'sd0, 16'sd0, 16'sd0);
      // odd count with negative x and z sums
      send_word(FUNC_ADD, -16'sd3, -16'sd4, 16'sd5);
      send_word(FUNC_ADD, 16'sd0, 16'sd0, 16'sd0);
      send_word(FUNC_ADD, -16'sd2, 16'sd7, -16'sd9);
      send_word(FUNC_FINISH, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      // all positive maximum
      send_word(FUNC_ADD, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_word(FUNC_ADD, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_word(FUNC_FINISH, 16'sd0, 16'sd0, 16'sd0);
      // all negative minimum, then a finish right after a finish
      send_word(FUNC_ADD, 16'sh8000, 16'sh8000, 16'sh8000);
      send_word(FUNC_ADD, 16'sh8000, 16'sh8000, 16'sh8000);
      send_word(FUNC_FINISH, 16'sd0, 16'sd0, 16'sd0);
      send_word(FUNC_FINISH, 16'sd0, 16'sd0, 16'sd0);
      wait_for_results();

      run_phase(26, 63, 478);
      run_phase(63, 26, 478);
      run_phase(0, 0, 478);

      wait_for_results();
      repeat (600) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("[point_set_mean_covariance] OK");
      else
         $display("[point_set_mean_covariance] ERROR");
      $finish;
   end

endmodule
